@@ rtl/trvg_pkg.sv @@
// shared types, register codes and sine table helper for the tube ring vertex generator
package trvg_pkg;

  // configuration register indexes
  typedef enum logic {
    CFG_RING_POINTS = 1'b0,
    CFG_PHASE_STEP  = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgDataW       = 16;
  localparam int unsigned RingPointsW    = 7;
  localparam int unsigned PhaseW         = 16;
  localparam logic [6:0]  RingPointsRst  = 7'd16;
  localparam logic [15:0] PhaseStepRst   = 16'd4096;

  // quarter-wave table magnitude width (0 .. 32767)
  localparam int unsigned SineMagW       = 15;
  // pi/2 in unsigned Q2.30
  localparam logic [63:0] HalfPiQ30      = 64'd1686629713;

  // one path frame
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] binormal_x;
    logic signed [15:0] binormal_y;
    logic signed [15:0] binormal_z;
    logic        [15:0] ring_radius;
  } frame_t;

  // one ring vertex
  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic signed [31:0] vert_z;
    logic               ring_last;
  } vert_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic issue;
    logic last;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic adv;
    logic pipe_busy;
  } stat_t;

  // one quarter-wave table entry, Taylor series in unsigned Q2.30 with truncated products
  function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] v;
    x    = (HalfPiQ30 * 64'(k)) >> qbits;
    sum  = x;
    term = x;
    for (int n = 1; n <= 8; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (n)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        6:       term = term / 156;
        7:       term = term / 210;
        8:       term = term / 272;
        default: term = term;
      endcase
      if ((n % 2) == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

@@ rtl/trvg_stream_if.sv @@
// valid/ready stream channel carrying one payload word per transfer
interface trvg_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/tube_ring_vertex_generator_core.sv @@
// tube ring vertex generator top level: configuration registers, sequencer and datapath
//
// channel    | dir | transfer                     | payload
// frame_i    | in  | valid & ready                | trvg_pkg::frame_t (centre, N, B, radius)
// vert_o     | out | valid & ready                | trvg_pkg::vert_t (vertex, ring_last)
// cfg        | in  | cfg_we_i, no wait            | cfg_idx_i, cfg_wdata_i
//
// a frame with n = min(ring_points, MAX_RING_POINTS) vertices is issued as follows:
// one vertex issued per cycle while the output register is not stalled, then the four
// stages ahead of the output register drain before the next frame; the last vertex may
// still sit in the output register. n of zero produces no transfer.
// a stalled output register freezes the whole vertex pipe; the input waits until it drains.
// reset restores ring_points 16 and phase_step 4096 and empties the pipe.
module tube_ring_vertex_generator_core #(
  parameter int unsigned MAX_RING_POINTS = 64,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  trvg_stream_if.sink                    frame_i,
  trvg_stream_if.source                  vert_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_idx_i,
  input  logic [trvg_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import trvg_pkg::*;

  logic [RingPointsW-1:0] ring_points_q;
  logic [PhaseW-1:0]      phase_step_q;
  cmd_t                   cmd;
  stat_t                  stat;
  logic                   in_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_points_q <= RingPointsRst;
      phase_step_q  <= PhaseStepRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_RING_POINTS: ring_points_q <= cfg_wdata_i[RingPointsW-1:0];
        CFG_PHASE_STEP:  phase_step_q  <= cfg_wdata_i[PhaseW-1:0];
        default: ;
      endcase
    end
  end

  assign frame_i.ready = in_ready;

  // sequencer
  trvg_ctrl #(
    .MAX_RING_POINTS (MAX_RING_POINTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (frame_i.valid),
    .in_ready_o    (in_ready),
    .ring_points_i (ring_points_q),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // vertex datapath
  trvg_dp #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .frame_i      (frame_i.data),
    .phase_step_i (phase_step_q),
    .vert_o       (vert_o)
  );

endmodule

@@ rtl/trvg_ctrl.sv @@
// ring sequencer: accepts frames and issues one vertex command per advancing cycle
module trvg_ctrl #(
  parameter int unsigned MAX_RING_POINTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [6:0]           ring_points_i,
  input  trvg_pkg::stat_t      stat_i,
  output trvg_pkg::cmd_t       cmd_o
);
  import trvg_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_RING_POINTS + 1);
  localparam int unsigned CmpW = (CntW > RingPointsW) ? CntW : RingPointsW;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic [CmpW-1:0]   rp_w;
  logic [CmpW-1:0]   max_w;
  logic [CmpW-1:0]   n_w;
  logic [CntW-1:0]   n_cnt;
  logic              accept;

  // clamp the ring size to the supported maximum
  always_comb begin
    rp_w  = CmpW'(ring_points_i);
    max_w = CmpW'(MAX_RING_POINTS);
    n_w   = (rp_w > max_w) ? max_w : rp_w;
    n_cnt = n_w[CntW-1:0];
  end

  // a new frame only once the previous ring has left the pipeline
  assign in_ready_o = (state_q == ST_IDLE) && !stat_i.pipe_busy;
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.load  = accept;
  assign cmd_o.issue = (state_q == ST_RUN);
  assign cmd_o.last  = (rem_q == CntW'(1));

  // next state and remaining vertex count
  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (n_cnt != '0)) begin
          state_d = ST_RUN;
          rem_d   = n_cnt;
        end
      end
      ST_RUN: begin
        if (stat_i.adv) begin
          rem_d = rem_q - CntW'(1);
          if (rem_q == CntW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        rem_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rem_q   <= '0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
    end
  end

`ifndef ASSERT_OFF
  a_start_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (n_cnt != '0)) |=> (state_q == ST_RUN) && (rem_q == $past(n_cnt)))
    else $error("ring did not start with the clamped vertex count");
  a_end_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.issue && cmd_o.last && stat_i.adv) |=> (state_q == ST_IDLE))
    else $error("sequencer kept running after the last vertex");
  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (rem_q != '0))
    else $error("running with no vertices left");
`endif

endmodule

@@ rtl/trvg_dp.sv @@
// vertex datapath: phase, sine lookup, radius and axis products, rounding and output register
module trvg_dp #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  trvg_pkg::cmd_t       cmd_i,
  output trvg_pkg::stat_t      stat_o,
  input  trvg_pkg::frame_t     frame_i,
  input  logic [15:0]          phase_step_i,
  trvg_stream_if.source        vert_o
);
  import trvg_pkg::*;

  localparam int unsigned Sb       = SINE_TABLE_BITS;
  localparam int unsigned Qb       = SINE_TABLE_BITS - 2;
  localparam int unsigned RomDepth = (1 << Qb) + 1;
  localparam int unsigned IdxW     = Qb + 1;
  localparam int unsigned QSteps   = 1 << Qb;
  localparam int unsigned SumW     = 56;
  localparam int unsigned RcW      = 33;
  localparam int unsigned PrW      = 49;

  typedef logic [SineMagW-1:0] rom_t [RomDepth];

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < RomDepth; k++) begin
      r[k] = sine_entry(k, Qb);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  // held frame
  logic signed [31:0]    center_q [3];
  logic signed [15:0]    axis_n_q [3];
  logic signed [15:0]    axis_b_q [3];
  logic        [15:0]    radius_q;

  logic        [15:0]    phase_q;
  logic                  adv;

  // issue stage lookup indexes
  logic [Sb-1:0]         angle;
  logic [1:0]            quad_s;
  logic [1:0]            quad_c;
  logic [Qb-1:0]         off;
  logic [IdxW-1:0]       sin_idx;
  logic [IdxW-1:0]       cos_idx;

  // stage 1: table data
  logic                  v1_q, l1_q;
  logic [SineMagW-1:0]   sin_mag_q, cos_mag_q;
  logic                  sin_neg_q, cos_neg_q;
  // stage 2: radius products
  logic                  v2_q, l2_q;
  logic signed [15:0]    sin_s, cos_s;
  logic signed [RcW-1:0] rs_q, rc_q;
  // stage 3: axis products
  logic                  v3_q, l3_q;
  logic signed [PrW-1:0] pn_q [3];
  logic signed [PrW-1:0] pb_q [3];
  // stage 4: full precision sums
  logic                  v4_q, l4_q;
  logic signed [SumW-1:0] total_q [3];
  // output register
  logic                  out_valid_q;
  vert_t                 out_data_q;
  logic signed [31:0]    sat [3];

  // the whole pipe moves unless a finished vertex is stuck in the output register
  assign adv              = !out_valid_q || vert_o.ready;
  assign stat_o.adv       = adv;
  assign stat_o.pipe_busy = v1_q || v2_q || v3_q || v4_q;

  // frame capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      center_q[0] <= frame_i.center_x;
      center_q[1] <= frame_i.center_y;
      center_q[2] <= frame_i.center_z;
      axis_n_q[0] <= frame_i.normal_x;
      axis_n_q[1] <= frame_i.normal_y;
      axis_n_q[2] <= frame_i.normal_z;
      axis_b_q[0] <= frame_i.binormal_x;
      axis_b_q[1] <= frame_i.binormal_y;
      axis_b_q[2] <= frame_i.binormal_z;
      radius_q    <= frame_i.ring_radius;
    end
  end

  // phase accumulator, restarted for every ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (cmd_i.load) begin
      phase_q <= '0;
    end else if (cmd_i.issue && adv) begin
      phase_q <= phase_q + phase_step_i;
    end
  end

  // quadrant folding: odd quadrants mirror the index, cos is a quarter turn ahead
  always_comb begin
    angle   = phase_q[15 -: Sb];
    quad_s  = angle[Sb-1:Sb-2];
    quad_c  = quad_s + 2'd1;
    off     = angle[Qb-1:0];
    sin_idx = quad_s[0] ? (IdxW'(QSteps) - {1'b0, off}) : {1'b0, off};
    cos_idx = quad_c[0] ? (IdxW'(QSteps) - {1'b0, off}) : {1'b0, off};
  end

  // pipeline valid and last flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  // table read
  always_ff @(posedge clk_i) begin
    if (adv) begin
      l1_q      <= cmd_i.last;
      sin_mag_q <= SineRom[sin_idx];
      cos_mag_q <= SineRom[cos_idx];
      sin_neg_q <= quad_s[1];
      cos_neg_q <= quad_c[1];
    end
  end

  // signed sine and cosine
  always_comb begin
    sin_s = sin_neg_q ? -$signed({1'b0, sin_mag_q}) : $signed({1'b0, sin_mag_q});
    cos_s = cos_neg_q ? -$signed({1'b0, cos_mag_q}) : $signed({1'b0, cos_mag_q});
  end

  // radius times sine and cosine
  always_ff @(posedge clk_i) begin
    if (adv) begin
      l2_q <= l1_q;
      rs_q <= $signed({1'b0, radius_q}) * sin_s;
      rc_q <= $signed({1'b0, radius_q}) * cos_s;
    end
  end

  // projection onto normal and binormal
  always_ff @(posedge clk_i) begin
    if (adv) begin
      l3_q <= l2_q;
      for (int d = 0; d < 3; d++) begin
        pn_q[d] <= rc_q * axis_n_q[d];
        pb_q[d] <= rs_q * axis_b_q[d];
      end
    end
  end

  // centre scaled to the product fraction plus both projections
  always_ff @(posedge clk_i) begin
    if (adv) begin
      l4_q <= l3_q;
      for (int d = 0; d < 3; d++) begin
        total_q[d] <= ($signed({{(SumW-32){center_q[d][31]}}, center_q[d]}) <<< 22)
                    + $signed({{(SumW-PrW){pn_q[d][PrW-1]}}, pn_q[d]})
                    + $signed({{(SumW-PrW){pb_q[d][PrW-1]}}, pb_q[d]});
      end
    end
  end

  // round half up, drop 22 fraction bits, saturate to Q16.16
  always_comb begin
    logic signed [SumW-1:0] rnd;
    logic signed [33:0]     sh;
    for (int d = 0; d < 3; d++) begin
      rnd = total_q[d] + $signed(SumW'(1 << 21));
      sh  = rnd[SumW-1:22];
      if ((sh[33:31] == 3'b000) || (sh[33:31] == 3'b111)) begin
        sat[d] = sh[31:0];
      end else if (sh[33]) begin
        sat[d] = 32'sh8000_0000;
      end else begin
        sat[d] = 32'sh7fff_ffff;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q.vert_x    <= sat[0];
      out_data_q.vert_y    <= sat[1];
      out_data_q.vert_z    <= sat[2];
      out_data_q.ring_last <= l4_q;
    end
  end

  assign vert_o.valid = out_valid_q;
  assign vert_o.data  = out_data_q;

`ifndef ASSERT_OFF
  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !stat_o.pipe_busy)
    else $error("frame loaded while vertices of the previous ring are in flight");
  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && adv) |=> out_valid_q)
    else $error("finished vertex did not reach the output register");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !vert_o.ready) |-> !adv)
    else $error("pipe advanced over an untaken vertex");
`endif

endmodule
